// ===== hw/rtl/vzc_pkg.sv =====
// vzc_pkg: shared widths, request and result codes for the varint/zigzag codec.
// No dependencies; used by varint_zigzag_codec_unit.
package vzc_pkg;

  localparam int unsigned ValW   = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned GrpW   = 7;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned KindW  = 2;
  localparam int unsigned MaxPos = 10;
  localparam int unsigned FullGrp = 9;   // groups that fit whole below bit 63

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;

  localparam logic [CmdW-1:0] CMD_ENC_U = 2'd0;
  localparam logic [CmdW-1:0] CMD_ENC_S = 2'd1;
  localparam logic [CmdW-1:0] CMD_DEC_U = 2'd2;
  localparam logic [CmdW-1:0] CMD_DEC_S = 2'd3;

  localparam logic [KindW-1:0] KIND_BYTE    = 2'd0;
  localparam logic [KindW-1:0] KIND_VALUE   = 2'd1;
  localparam logic [KindW-1:0] KIND_INVALID = 2'd2;
  localparam logic [KindW-1:0] KIND_BOUNDS  = 2'd3;

  localparam logic [ValW-1:0] HIGH_BITS = 64'he000_0000_0000_0000;

endpackage

// ===== hw/rtl/varint_zigzag_codec_unit.sv =====
// varint_zigzag_codec_unit: LEB128 varint encoder/decoder with optional zigzag.
// Depends on vzc_pkg. Single shared 7-bit shift/emit unit under a small sequencer.
// Results are registered; a request's first output is loaded when the request is taken.
// Throughput: decode takes one byte per cycle, and encode emits one output byte per cycle,
// while the output is not stalled; an N-byte encode (N = 1..10) holds the input until done.
// Output stalls stall the sequencer. Reset (sync, rst_n low) clears decode state and output.
module varint_zigzag_codec_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vzc_pkg::InDataW-1:0]       in_tdata,   // value_in[63:0], byte_in[71:64]
  input  logic [vzc_pkg::CmdW-1:0]          in_tuser,   // command[1:0]
  input  logic                              in_tlast,   // final_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vzc_pkg::OutDataW-1:0]      out_tdata,  // byte_out[7:0], value_out[71:8]
  output logic [vzc_pkg::KindW-1:0]         out_tuser,  // kind[1:0]
  output logic                              out_tlast   // last
);

  typedef enum logic {S_IDLE, S_ENC} state_t;

  state_t                        state_r, state_nxt;
  logic [vzc_pkg::ValW-1:0]      rem_r, rem_nxt;
  logic [vzc_pkg::ValW-1:0]      acc_r, acc_nxt;
  logic [vzc_pkg::PosW-1:0]      pos_r, pos_nxt;
  logic                          ov_r, ov_nxt;
  logic [vzc_pkg::KindW-1:0]     okind_r, okind_nxt;
  logic [vzc_pkg::ByteW-1:0]     obyte_r, obyte_nxt;
  logic [vzc_pkg::ValW-1:0]      oval_r, oval_nxt;
  logic                          olast_r, olast_nxt;

  logic                          out_free, in_req;
  logic [vzc_pkg::ValW-1:0]      value_in, zz_enc, enc_src, acc_ins, dec_val;
  logic [vzc_pkg::ByteW-1:0]     byte_in;
  logic [vzc_pkg::GrpW-1:0]      payload;
  logic [vzc_pkg::CmdW-1:0]      cmd;
  logic                          is_enc;

  assign value_in = in_tdata[vzc_pkg::ValW-1:0];
  assign byte_in  = in_tdata[vzc_pkg::InDataW-1:vzc_pkg::ValW];
  assign cmd      = in_tuser;
  assign payload  = byte_in[vzc_pkg::GrpW-1:0];
  assign is_enc   = (cmd == vzc_pkg::CMD_ENC_U) || (cmd == vzc_pkg::CMD_ENC_S);

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_req    = in_tvalid && in_tready;

  assign zz_enc  = {value_in[vzc_pkg::ValW-2:0], 1'b0} ^ {vzc_pkg::ValW{value_in[vzc_pkg::ValW-1]}};
  assign enc_src = (state_r == S_ENC) ? rem_r :
                   ((cmd == vzc_pkg::CMD_ENC_S) ? zz_enc : value_in);

  // insert the 7 payload bits at the current group; the tenth group keeps only bit 63
  always_comb begin
    acc_ins = acc_r;
    for (int k = 0; k < vzc_pkg::FullGrp; k++) begin
      if (pos_r == vzc_pkg::PosW'(k)) begin
        acc_ins[k*vzc_pkg::GrpW +: vzc_pkg::GrpW] =
          acc_r[k*vzc_pkg::GrpW +: vzc_pkg::GrpW] | payload;
      end
    end
    if (pos_r == vzc_pkg::PosW'(vzc_pkg::FullGrp)) begin
      acc_ins[vzc_pkg::ValW-1] = acc_r[vzc_pkg::ValW-1] | payload[0];
    end
  end

  assign dec_val = (cmd == vzc_pkg::CMD_DEC_S) ?
                   ({1'b0, acc_ins[vzc_pkg::ValW-1:1]} ^ {vzc_pkg::ValW{acc_ins[0]}}) : acc_ins;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    ov_nxt    = ov_r && !out_tready;
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    if ((state_r == S_ENC && out_free) || (in_req && is_enc)) begin
      // shared emit unit: low group out, remainder shifted by one group
      ov_nxt    = 1'b1;
      okind_nxt = vzc_pkg::KIND_BYTE;
      oval_nxt  = '0;
      rem_nxt   = enc_src >> vzc_pkg::GrpW;
      if (enc_src[vzc_pkg::ValW-1:vzc_pkg::GrpW] != '0) begin
        obyte_nxt = {1'b1, enc_src[vzc_pkg::GrpW-1:0]};
        olast_nxt = 1'b0;
        state_nxt = S_ENC;
      end else begin
        obyte_nxt = {1'b0, enc_src[vzc_pkg::GrpW-1:0]};
        olast_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
    end else if (in_req) begin
      obyte_nxt = '0;
      oval_nxt  = '0;
      olast_nxt = 1'b1;
      acc_nxt   = '0;
      pos_nxt   = '0;
      ov_nxt    = 1'b1;
      priority if (pos_r >= vzc_pkg::PosW'(vzc_pkg::MaxPos)) begin
        okind_nxt = vzc_pkg::KIND_INVALID;
      end else if (!byte_in[vzc_pkg::ByteW-1]) begin
        okind_nxt = vzc_pkg::KIND_VALUE;
        oval_nxt  = dec_val;
      end else if ((acc_ins & vzc_pkg::HIGH_BITS) != '0) begin
        okind_nxt = vzc_pkg::KIND_INVALID;
      end else if (in_tlast) begin
        okind_nxt = vzc_pkg::KIND_BOUNDS;
      end else begin
        ov_nxt  = 1'b0;
        acc_nxt = acc_ins;
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
      pos_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      ov_r    <= ov_nxt;
    end
    rem_r   <= rem_nxt;
    okind_r <= okind_nxt;
    obyte_r <= obyte_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {oval_r, obyte_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  a_no_req_enc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) |-> !in_tready) else $error("request taken during encode");
  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) |-> (rem_r != '0)) else $error("encode running with empty remainder");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= vzc_pkg::PosW'(vzc_pkg::MaxPos)) else $error("byte position past limit");
  a_dec_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r != vzc_pkg::KIND_BYTE) |-> (olast_r && obyte_r == '0))
    else $error("decode result malformed");
  a_enc_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == vzc_pkg::KIND_BYTE) |-> (obyte_r[vzc_pkg::ByteW-1] == !olast_r))
    else $error("continuation bit disagrees with last");

endmodule

// ===== tb/varint_zigzag_codec_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for varint_zigzag_codec_unit: directed and random encode/decode
// requests, with results predicted in-bench and checked in order. Depends on vzc_pkg.
module varint_zigzag_codec_unit_test;
  import vzc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PRESSURE_CYCLES = 300;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ValW-1:0]  value;
    logic [ByteW-1:0] byte_in;
    logic             fin;
  } codec_req_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] byte_out;
    logic [ValW-1:0]  value_out;
    logic             last;
  } codec_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;   // value_in[63:0], byte_in[71:64]
  logic [CmdW-1:0]     in_tuser = '0;   // command[1:0]
  logic                in_tlast = 1'b0; // final_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;       // byte_out[7:0], value_out[71:8]
  logic [KindW-1:0]    out_tuser;       // kind[1:0]
  logic                out_tlast;       // last

  varint_zigzag_codec_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  codec_req_t    pending_reqs[$];
  codec_result_t expected_results[$];
  codec_req_t    cur_req;
  logic [ValW-1:0] dec_acc = '0;
  logic [PosW-1:0] dec_pos = '0;
  int total_reqs = 0;
  int reqs_accepted = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_req(logic [CmdW-1:0] cmd, logic [ValW-1:0] value,
                                   logic [ByteW-1:0] b, logic fin);
    codec_req_t r;
    r.cmd = cmd;
    r.value = value;
    r.byte_in = b;
    r.fin = fin;
    pending_reqs.push_back(r);
  endfunction

  function automatic void expect_result(logic [KindW-1:0] kind, logic [ByteW-1:0] b,
                                        logic [ValW-1:0] v, logic last);
    codec_result_t e;
    e.kind = kind;
    e.byte_out = b;
    e.value_out = v;
    e.last = last;
    expected_results.push_back(e);
  endfunction

  function automatic void clear_decode();
    dec_acc = '0;
    dec_pos = '0;
  endfunction

  // Expected results of one accepted request; updates the decode state.
  function automatic void predict_codec(codec_req_t r);
    logic [ValW-1:0] rem;
    logic [ValW-1:0] v;
    int shamt;
    if (r.cmd == CMD_ENC_U || r.cmd == CMD_ENC_S) begin
      rem = r.value;
      if (r.cmd == CMD_ENC_S) begin
        rem = r.value[ValW-1] ? ((r.value << 1) ^ '1) : (r.value << 1);
      end
      while (rem > 64'h7f) begin
        expect_result(KIND_BYTE, {1'b1, rem[GrpW-1:0]}, '0, 1'b0);
        rem = rem >> GrpW;
      end
      expect_result(KIND_BYTE, {1'b0, rem[GrpW-1:0]}, '0, 1'b1);
    end else if (dec_pos >= MaxPos) begin
      clear_decode();
      expect_result(KIND_INVALID, '0, '0, 1'b1);
    end else begin
      shamt = int'(dec_pos) * GrpW;
      dec_acc = dec_acc | (ValW'(r.byte_in[GrpW-1:0]) << shamt);
      if (!r.byte_in[ByteW-1]) begin
        v = dec_acc;
        if (r.cmd == CMD_DEC_S) begin
          v = v[0] ? ((v >> 1) ^ '1) : (v >> 1);
        end
        clear_decode();
        expect_result(KIND_VALUE, '0, v, 1'b1);
      end else if ((dec_acc & HIGH_BITS) != '0) begin
        clear_decode();
        expect_result(KIND_INVALID, '0, '0, 1'b1);
      end else if (r.fin) begin
        clear_decode();
        expect_result(KIND_BOUNDS, '0, '0, 1'b1);
      end else begin
        dec_pos = dec_pos + 1'b1;
      end
    end
  endfunction

  function automatic int test_phase();
    if (reqs_accepted * 3 < total_reqs) return 0;
    if (reqs_accepted * 3 < total_reqs * 2) return 1;
    return 2;
  endfunction

  function automatic logic [CmdW-1:0] rand_dec_cmd();
    return $urandom_range(0, 1) ? CMD_DEC_S : CMD_DEC_U;
  endfunction

  function automatic void check_field(string what, logic [ValW-1:0] want,
                                      logic [ValW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Sender: keeps a request on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_codec(cur_req);
        reqs_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 &&
            $urandom_range(0, 99) >= (test_phase() == 0 ? 10 : test_phase() == 1 ? 70 : 0)) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_req.byte_in, cur_req.value};
          in_tuser <= cur_req.cmd;
          in_tlast <= cur_req.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with one long hold-off when the last phase starts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (test_phase() == 2 && !pressure_done) begin
      out_tready <= 1'b0;
      hold_left <= PRESSURE_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_tready <= $urandom_range(0, 99) >= (test_phase() == 0 ? 70 : test_phase() == 1 ? 10 : 0);
    end
  end

  always @(posedge clk) begin
    codec_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d data %h last %b",
                 $time, out_tuser, out_tdata, out_tlast);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("kind", ValW'(exp_res.kind), ValW'(out_tuser));
        check_field("byte_out", ValW'(exp_res.byte_out), ValW'(out_tdata[ByteW-1:0]));
        check_field("value_out", exp_res.value_out, out_tdata[ByteW +: ValW]);
        check_field("last", ValW'(exp_res.last), ValW'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int len;
    int sel;
    logic [ValW-1:0] v;
    logic [GrpW-1:0] payload;
    logic cont;

    // directed: encode extremes
    push_req(CMD_ENC_U, 64'h0, 8'hff, 1'b1);
    push_req(CMD_ENC_U, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0);
    push_req(CMD_ENC_U, 64'h80, 8'h5a, 1'b0);
    push_req(CMD_ENC_S, 64'h8000_0000_0000_0000, 8'ha5, 1'b1);
    push_req(CMD_ENC_S, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0);
    // single-byte signed decode, then continuation marked final
    push_req(CMD_DEC_S, 64'hffff_ffff_ffff_ffff, 8'h01, 1'b1);
    push_req(CMD_DEC_U, 64'h0, 8'h80, 1'b1);
    // ten continuation bytes (last one's payload falls past bit 63), then an eleventh
    for (int i = 0; i < 9; i++) push_req(i[0] ? CMD_DEC_S : CMD_DEC_U, 64'h0, 8'h80, 1'b0);
    push_req(CMD_DEC_U, 64'h0, 8'h82, 1'b0);
    push_req(CMD_DEC_S, 64'h0, 8'h00, 1'b1);
    // continuation that sets the top accumulator bits
    for (int i = 0; i < 8; i++) push_req(CMD_DEC_U, 64'h0, 8'h80, 1'b0);
    push_req(CMD_DEC_U, 64'h0, 8'hff, 1'b1);

    n = 0;
    while (n < 400) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 3) == 0) v = ~v;
        push_req($urandom_range(0, 1) ? CMD_ENC_S : CMD_ENC_U, v,
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        n++;
      end else if (sel < 80) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          cont = (i < len - 1);
          payload = 7'($urandom_range(0, 127));
          if (i == 8 && cont) payload = payload & 7'h1f;
          push_req(rand_dec_cmd(), {$urandom, $urandom}, {cont, payload},
                   cont ? 1'b0 : 1'($urandom_range(0, 1)));
        end
        n += len;
      end else if (sel < 90) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          push_req(rand_dec_cmd(), {$urandom, $urandom}, 8'h80 | 8'($urandom_range(0, 127)),
                   (i == len - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
        end
        n += len;
      end else begin
        push_req(rand_dec_cmd(), {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        n++;
      end
    end
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
